@@ hw/rtl/contiguous_buffer_pool_allocator_macros.svh @@
// Assertion macros for the buffer pool allocator
`ifndef CONTIGUOUS_BUFFER_POOL_ALLOCATOR_MACROS_SVH
`define CONTIGUOUS_BUFFER_POOL_ALLOCATOR_MACROS_SVH
// Check an implication on every clock edge outside reset
`define CBPA_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// Check that the consequent holds in the cycle after the antecedent
`define CBPA_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

@@ hw/rtl/cbpa_pkg.sv @@
// Shared types and codes for the buffer pool allocator
package cbpa_pkg;
  localparam logic [1:0] REQ_ALLOC = 2'd0;
  localparam logic [1:0] REQ_RELEASE = 2'd1;
  localparam logic [1:0] REQ_RELEASE_ALL = 2'd2;
  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_NO_ROOM = 2'd1;
  localparam logic [1:0] ST_BAD = 2'd2;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [15:0] size_bytes;
    logic [7:0]  owner_id;
    logic [31:0] release_address;
  } request_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] granted_address;
    logic [6:0]  buffers_in_use;
    logic [6:0]  buffers_freed;
  } result_t;
endpackage

@@ hw/rtl/cbpa_cell.sv @@
// One tag cell of the rotating tag ring
module cbpa_cell #(
  parameter int LW = 9,
  parameter int PW = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          load,
  input  logic [7:0]    in_owner,
  input  logic [LW-1:0] in_len,
  input  logic [PW-1:0] in_pos,
  output logic [7:0]    owner,
  output logic [LW-1:0] len,
  output logic [PW-1:0] pos
);
  // Take the neighbor's tag when the ring advances
  always_ff @(posedge clk) begin
    if (rst) begin
      owner <= '0;
      len <= '0;
      pos <= '0;
    end else if (load) begin
      owner <= in_owner;
      len <= in_len;
      pos <= in_pos;
    end
  end
endmodule

@@ hw/rtl/contiguous_buffer_pool_allocator.sv @@
// Buffer pool allocator: tag ring of BUFFER_COUNT cells and a control sequencer.
// A granted allocate or a release of a run makes a scan or locate pass, then a
// write pass round the ring; release-all, an allocate that the scan finds no room
// for and a bad release make one pass; other bad requests and oversized allocates
// go straight to done. A new request is taken only when idle; results never stall.
// Synchronous reset clears every tag, the in-use count and pool_base.
module contiguous_buffer_pool_allocator #(
  parameter int BUFFER_COUNT = 64,
  parameter int BUFFER_BYTES = 256
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  cbpa_pkg::request_t req,
  output logic               busy,
  output logic               done,
  output cbpa_pkg::result_t  result,
  input  logic               cfg_we,
  input  logic [31:0]        cfg_wdata
);
`include "contiguous_buffer_pool_allocator_macros.svh"
  localparam int IW = $clog2(BUFFER_COUNT);
  localparam int CW = $clog2(BUFFER_COUNT + 1);
  localparam int LW = CW;
  localparam int PW = (IW < 1) ? 1 : IW;
  localparam int SH = $clog2(BUFFER_BYTES);
  localparam int NW = 17;

  typedef enum logic [2:0] {S_IDLE, S_SCAN, S_FIND, S_FREE, S_DONE} state_t;
  state_t state;

  logic [31:0] pool_base;
  logic [7:0] c_owner [BUFFER_COUNT];
  logic [LW-1:0] c_len [BUFFER_COUNT];
  logic [PW-1:0] c_pos [BUFFER_COUNT];
  logic [7:0] w_owner;
  logic [LW-1:0] w_len;
  logic [PW-1:0] w_pos;
  logic adv;

  // Ring: tags shift toward head cell 0, which is inspected and rewritten into the tail
  for (genvar g = 0; g < BUFFER_COUNT; g++) begin : g_ring
    if (g == BUFFER_COUNT - 1) begin : g_tail
      cbpa_cell #(.LW(LW), .PW(PW)) u_cell (.clk, .rst, .load(adv),
        .in_owner(w_owner), .in_len(w_len), .in_pos(w_pos),
        .owner(c_owner[g]), .len(c_len[g]), .pos(c_pos[g]));
    end else begin : g_mid
      cbpa_cell #(.LW(LW), .PW(PW)) u_cell (.clk, .rst, .load(adv),
        .in_owner(c_owner[g+1]), .in_len(c_len[g+1]), .in_pos(c_pos[g+1]),
        .owner(c_owner[g]), .len(c_len[g]), .pos(c_pos[g]));
    end
  end

  cbpa_pkg::request_t r;
  logic [CW-1:0] used, freed, need, run;
  logic [IW:0] idx, start_i, tgt, lim;
  logic found;
  logic rel_ok, hit;
  logic [1:0] st;
  logic [31:0] off;
  logic [NW-1:0] need_w;
  logic [31:0] bidx;

  assign need_w = NW'((17'(req.size_bytes) + 17'(BUFFER_BYTES - 1)) >> SH);
  assign off = r.release_address - pool_base;
  assign bidx = off >> SH;
  assign tgt = (IW+1)'(bidx);
  assign lim = (IW+1)'(BUFFER_COUNT) - tgt;
  assign rel_ok = (r.release_address >= pool_base) && (bidx < 32'(BUFFER_COUNT));
  assign hit = rel_ok && (idx == tgt) && (c_owner[0] != '0) && (c_pos[0] == '0);
  assign busy = (state != S_IDLE);

  // Writeback of the head cell during a pass
  always_comb begin
    w_owner = c_owner[0];
    w_len = c_len[0];
    w_pos = c_pos[0];
    adv = (state == S_SCAN) || (state == S_FIND) || (state == S_FREE);
    if (state == S_SCAN && r.req_type == cbpa_pkg::REQ_RELEASE_ALL) begin
      if (c_owner[0] == r.owner_id) begin
        w_owner = '0; w_len = '0; w_pos = '0;
      end
    end else if (state == S_FREE) begin
      if (found && (idx >= start_i) && (idx < start_i + (IW+1)'(need))) begin
        if (r.req_type == cbpa_pkg::REQ_ALLOC) begin
          w_owner = r.owner_id; w_len = need;
          w_pos = PW'(idx - start_i);
        end else begin
          w_owner = '0; w_len = '0; w_pos = '0;
        end
      end
    end
  end

  // Sequencer: state and registered result
  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      state <= S_IDLE;
      pool_base <= '0;
      used <= '0;
      result <= '0;
      idx <= '0; start_i <= '0; found <= 1'b0; run <= '0;
      need <= '0; freed <= '0; st <= cbpa_pkg::ST_OK;
    end else begin
      if (cfg_we) pool_base <= cfg_wdata;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            r <= req;
            idx <= '0; run <= '0; found <= 1'b0; freed <= '0; start_i <= '0;
            need <= (need_w > NW'(BUFFER_COUNT)) ? '0 : CW'(need_w);
            st <= cbpa_pkg::ST_OK;
            state <= S_SCAN;
            if (req.req_type == cbpa_pkg::REQ_ALLOC) begin
              if (req.owner_id == '0 || req.size_bytes == '0) begin
                st <= cbpa_pkg::ST_BAD; state <= S_DONE;
              end else if (need_w > NW'(BUFFER_COUNT)) begin
                st <= cbpa_pkg::ST_NO_ROOM; state <= S_DONE;
              end
            end else if (req.req_type == cbpa_pkg::REQ_RELEASE) begin
              state <= S_FIND;
            end else if (req.req_type == cbpa_pkg::REQ_RELEASE_ALL) begin
              if (req.owner_id == '0) begin
                st <= cbpa_pkg::ST_BAD; state <= S_DONE;
              end
            end else begin
              st <= cbpa_pkg::ST_BAD; state <= S_DONE;
            end
          end
        end
        S_SCAN: begin
          idx <= idx + 1'b1;
          if (r.req_type == cbpa_pkg::REQ_RELEASE_ALL) begin
            if (c_owner[0] == r.owner_id) begin
              freed <= freed + 1'b1;
              used <= used - 1'b1;
            end
          end else if (!found) begin
            if (c_owner[0] != '0) run <= '0;
            else begin
              if (run == '0) start_i <= idx;
              run <= run + 1'b1;
              if (run + 1'b1 == need) begin
                found <= 1'b1;
                if (run == '0) start_i <= idx;
              end
            end
          end
          if (idx == (IW+1)'(BUFFER_COUNT - 1)) begin
            idx <= '0;
            if (r.req_type == cbpa_pkg::REQ_RELEASE_ALL) state <= S_DONE;
            else if (found || (c_owner[0] == '0 && run + 1'b1 == need))
              state <= S_FREE;
            else begin
              st <= cbpa_pkg::ST_NO_ROOM; state <= S_DONE;
            end
          end
        end
        S_FIND: begin
          // Latch the run as its first buffer passes the head, cut at the pool end
          if (hit) begin
            found <= 1'b1;
            start_i <= tgt;
            need <= ((IW+1)'(c_len[0]) > lim) ? CW'(lim) : c_len[0];
          end
          if (idx == (IW+1)'(BUFFER_COUNT - 1)) begin
            idx <= '0;
            if (found || hit) state <= S_FREE;
            else begin
              st <= cbpa_pkg::ST_BAD; state <= S_DONE;
            end
          end else begin
            idx <= idx + 1'b1;
          end
        end
        S_FREE: begin
          idx <= idx + 1'b1;
          if (found && (idx >= start_i) && (idx < start_i + (IW+1)'(need))) begin
            if (r.req_type == cbpa_pkg::REQ_ALLOC) used <= used + 1'b1;
            else begin
              freed <= freed + 1'b1;
              if (used != '0) used <= used - 1'b1;
            end
          end
          if (idx == (IW+1)'(BUFFER_COUNT - 1)) state <= S_DONE;
        end
        S_DONE: begin
          done <= 1'b1;
          state <= S_IDLE;
          result.status <= st;
          result.buffers_in_use <= 7'(used);
          result.buffers_freed <= (st == cbpa_pkg::ST_OK) ? 7'(freed) : '0;
          result.granted_address <= (st == cbpa_pkg::ST_OK &&
            r.req_type == cbpa_pkg::REQ_ALLOC) ?
            pool_base + (32'(start_i) << SH) : '0;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `CBPA_ASSERT_IMP(a_done_idle, clk, rst, done, state == S_IDLE)
  `CBPA_ASSERT_IMP(a_used_range, clk, rst, 1'b1, used <= CW'(BUFFER_COUNT))
  `CBPA_ASSERT_NEXT(a_start_busy, clk, rst, start && !busy, busy)
endmodule
